/* src/mms_pkg.sv */
// Package for the min/max stack: request and result beats, codes and lane control.
package mms_pkg;

  // Default geometry of the stack.
  localparam int unsigned DEF_STACK_DEPTH = 256;
  localparam int unsigned DEF_DATA_WIDTH  = 32;

  // Fixed widths of the beat fields.
  localparam int unsigned FIELD_W = 32;
  localparam int unsigned DEPTH_W = 9;

  typedef enum logic [0:0] {
    REQ_PUSH = 1'b0,
    REQ_POP  = 1'b1
  } req_type_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_POP_EMPTY = 2'd1,
    ST_PUSH_FULL = 2'd2
  } status_t;

  typedef struct packed {
    logic [0:0]                req_type;
    logic signed [FIELD_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] top_value;
    logic signed [FIELD_W-1:0] max_value;
    logic signed [FIELD_W-1:0] min_value;
    logic [DEPTH_W-1:0]        depth;
    logic [1:0]                status;
  } out_item_t;

  // Per-lane command for one cycle.
  typedef struct packed {
    logic push;
    logic pop;
  } lane_ctrl_t;

endpackage

/* src/min_max_stack_top.sv */
// Top level of the min/max stack: request decode, three stack lanes, result beat.
//
//  channel  | ports                      | handshake
//  ---------+----------------------------+------------------------------------
//  request  | start, busy, in_data       | beat taken when start & !busy
//  result   | out_strobe, out_data       | one-cycle strobe, cannot be held off
//
// Each request's result beat appears in the cycle after the accepting edge,
// and a new request may be accepted in that same cycle.
// A popping lane reads the entry under the old top from its memory, and
// that registered read data is the new top.
// busy stays low; reset empties all three stacks, memory contents are left as
// they are and only written entries ever reach a result.
// The receiver cannot stall, so no result is ever held back.
module min_max_stack_top
  import mms_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = DEF_STACK_DEPTH,
  parameter int unsigned DATA_WIDTH  = DEF_DATA_WIDTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_data,
  output logic      out_strobe,
  output out_item_t out_data
);

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  logic                         accept;
  logic                         is_push;
  logic                         is_pop;
  logic                         full;
  logic                         push_ok;
  logic                         pop_ok;
  logic signed [DATA_WIDTH-1:0] wval;

  lane_ctrl_t                   val_ctrl;
  lane_ctrl_t                   max_ctrl;
  lane_ctrl_t                   min_ctrl;
  logic [CW-1:0]                val_cnt;
  logic [CW-1:0]                max_cnt;
  logic [CW-1:0]                min_cnt;
  logic signed [DATA_WIDTH-1:0] val_top;
  logic signed [DATA_WIDTH-1:0] max_top;
  logic signed [DATA_WIDTH-1:0] min_top;

  status_t                      status_r;
  status_t                      status_nxt;
  logic                         strobe_r;

  // Requests never wait: busy is tied low and every lane updates on the accepting edge.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign is_push = accept && (in_data.req_type == REQ_PUSH);
  assign is_pop  = accept && (in_data.req_type == REQ_POP);
  assign full    = (val_cnt == CW'(STACK_DEPTH));
  assign wval    = DATA_WIDTH'(in_data.value);

  // Drop a push on a full stack and a pop on an empty one.
  assign push_ok = is_push && !full;
  assign pop_ok  = is_pop && (val_cnt != '0);

  // Main lane follows every valid push and pop.
  assign val_ctrl.push = push_ok;
  assign val_ctrl.pop  = pop_ok;

  // Aux lanes take a push only when it reaches or passes their top, and
  // drop their top when it equals the popped word.
  assign max_ctrl.push = push_ok && ((max_cnt == '0) || (wval >= max_top));
  assign max_ctrl.pop  = pop_ok && (max_cnt != '0) && (max_top == val_top);
  assign min_ctrl.push = push_ok && ((min_cnt == '0) || (wval <= min_top));
  assign min_ctrl.pop  = pop_ok && (min_cnt != '0) && (min_top == val_top);

  mms_lane #(.DEPTH(STACK_DEPTH), .DW(DATA_WIDTH)) u_val_lane (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (val_ctrl),
    .wdata (wval),
    .count (val_cnt),
    .top   (val_top)
  );

  mms_lane #(.DEPTH(STACK_DEPTH), .DW(DATA_WIDTH)) u_max_lane (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (max_ctrl),
    .wdata (wval),
    .count (max_cnt),
    .top   (max_top)
  );

  mms_lane #(.DEPTH(STACK_DEPTH), .DW(DATA_WIDTH)) u_min_lane (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (min_ctrl),
    .wdata (wval),
    .count (min_cnt),
    .top   (min_top)
  );

  always_comb begin
    status_nxt = ST_DONE;
    if (is_push && full) begin
      status_nxt = ST_PUSH_FULL;
    end else if (is_pop && (val_cnt == '0)) begin
      status_nxt = ST_POP_EMPTY;
    end
  end

  // Hold the status for the result beat; strobe once per accepted request.
  always_ff @(posedge clk) begin
    status_r <= status_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= accept;
    end
  end

  // The lanes already show the post-request state in the beat cycle.
  assign out_strobe         = strobe_r;
  assign out_data.top_value = (val_cnt != '0) ? FIELD_W'(val_top) : '0;
  assign out_data.max_value = ((val_cnt != '0) && (max_cnt != '0)) ?
                              FIELD_W'(max_top) : '0;
  assign out_data.min_value = ((val_cnt != '0) && (min_cnt != '0)) ?
                              FIELD_W'(min_top) : '0;
  assign out_data.depth     = DEPTH_W'(val_cnt);
  assign out_data.status    = status_r;

  // Aux stacks never outgrow the main stack.
  a_aux_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (max_cnt <= val_cnt) && (min_cnt <= val_cnt))
    else $error("aux stack deeper than main stack");

  // A non-empty stack always has a max and a min entry.
  a_aux_present: assert property (@(posedge clk) disable iff (!rst_n)
    (val_cnt != '0) |-> ((max_cnt != '0) && (min_cnt != '0)))
    else $error("aux stack empty while main stack holds entries");

  // One result beat per accepted request, in the next cycle.
  a_beat_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_strobe)
    else $error("accepted request without result beat");

  // An ignored pop reports an empty stack.
  a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_data.status == ST_POP_EMPTY)) |-> (val_cnt == '0))
    else $error("pop on empty flagged with entries present");

endmodule

/* src/mms_lane.sv */
// One stack lane: entry memory, entry count and a cached top word.
module mms_lane
  import mms_pkg::*;
#(
  parameter int unsigned DEPTH = DEF_STACK_DEPTH,
  parameter int unsigned DW    = DEF_DATA_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  lane_ctrl_t                       ctrl,
  input  logic signed [DW-1:0]             wdata,
  output logic [$clog2(DEPTH+1)-1:0]       count,
  output logic signed [DW-1:0]             top
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned AW = $clog2(DEPTH);

  logic signed [DW-1:0] mem [DEPTH];
  logic signed [DW-1:0] rd_q;
  logic signed [DW-1:0] top_r;
  logic [CW-1:0]        count_r;
  logic [CW-1:0]        count_nxt;
  logic                 sel_rd_r;
  logic                 sel_rd_nxt;
  logic [AW-1:0]        wr_addr;
  logic [AW-1:0]        rd_addr;

  // Push lands at the current count; pop fetches the entry under the old top.
  assign wr_addr = count_r[AW-1:0];
  assign rd_addr = AW'(count_r - CW'(2));

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      mem[wr_addr] <= wdata;
    end
    if (ctrl.pop) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      top_r <= wdata;
    end
  end

  always_comb begin
    count_nxt  = count_r;
    sel_rd_nxt = sel_rd_r;
    if (ctrl.push) begin
      count_nxt  = count_r + CW'(1);
      sel_rd_nxt = 1'b0;
    end else if (ctrl.pop) begin
      count_nxt  = count_r - CW'(1);
      sel_rd_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      sel_rd_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      sel_rd_r <= sel_rd_nxt;
    end
  end

  assign count = count_r;
  // After a pop the top is the word just read back from memory.
  assign top   = sel_rd_r ? rd_q : top_r;

endmodule
